// ===== hdl/assert_macros.svh =====
// Assertion macros of the glyph blender, included by its top level.
// Needs nothing else; each macro takes a label, clock, active-low reset and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gcab_pkg.sv =====
// Package of the glyph coverage alpha blender: widths, register codes, types,
// the gamma ROM and the divide-by-255 helper. Depends on nothing.
`timescale 1ns / 1ps

package gcab_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM) + 1;
  localparam int unsigned COORD_W   = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned NSTEP     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_COLOR    = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_CLIP_MIN_X    = 3'd3,
    REG_CLIP_MIN_Y    = 3'd4,
    REG_CLIP_MAX_X    = 3'd5,
    REG_CLIP_MAX_Y    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0]      text_color;
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
    logic [DIM_W-1:0] clip_min_x;
    logic [DIM_W-1:0] clip_min_y;
    logic [DIM_W-1:0] clip_max_x;
    logic [DIM_W-1:0] clip_max_y;
  } cfg_t;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        at;
    logic [31:0]       bgp;
  } entry_t;

  typedef logic [255:0][7:0] gamma_rom_t;

  function automatic gamma_rom_t build_gamma();
    gamma_rom_t rom;
    real        r;
    for (int i = 0; i < 256; i++) begin
      r = 255.0 * $pow(real'(i) / 255.0, 0.85);
      rom[i] = 8'($rtoi(r + 0.5));
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();

  // Exact floor(x / 255) for x up to 65279, the largest whose quotient fits in 8 bits.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== hdl/gcab_if.sv =====
// Channel interfaces of the glyph blender: pixel input, result output and
// configuration writes. Depends on nothing.
`timescale 1ns / 1ps

interface gcab_pix_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]         coverage;
  logic [31:0]        background_pixel;

  modport source (output valid, pixel_x, pixel_y, coverage, background_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, coverage, background_pixel, output ready);
endinterface

interface gcab_pix_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [23:0] pixel_address;
  logic [31:0] blended_pixel;

  modport source (output valid, write_enable, pixel_address, blended_pixel, input ready);
  modport sink (input valid, write_enable, pixel_address, blended_pixel, output ready);
endinterface

interface gcab_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/gcab_front.sv =====
// Front end of the glyph blender: clips each pixel, forms the address and the
// gamma-shaped text alpha. Depends on gcab_pkg and gcab_pix_in_if.
`timescale 1ns / 1ps

module gcab_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gcab_pkg::cfg_t  cfg_i,
  gcab_pix_in_if.sink     pix_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gcab_pkg::entry_t out_data_o
);
  import gcab_pkg::*;

  logic                       en;
  logic signed [16:0]         px_s, py_s;
  logic                       in_x, in_y;
  logic [DIM_W-1:0]           sw_sat, sh_sat;
  logic [7:0]                 fa;
  logic [COORD_W+DIM_W-1:0]   addr_mul;

  logic                       s1_valid_q, s1_keep_q;
  logic [15:0]                s1_prod_q;
  logic [ADDR_W-1:0]          s1_addr_q;
  logic [COORD_W-1:0]         s1_px_q;
  logic [31:0]                s1_bgp_q;

  logic                       s2_valid_q;
  entry_t                     s2_q, s2_d;

  assign en          = !s2_valid_q || out_ready_i;
  assign pix_i.ready = en;

  always_comb begin
    px_s   = {pix_i.pixel_x[15], pix_i.pixel_x};
    py_s   = {pix_i.pixel_y[15], pix_i.pixel_y};
    sw_sat = (cfg_i.screen_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.screen_width;
    sh_sat = (cfg_i.screen_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.screen_height;
    in_x   = !px_s[16]
          && (px_s >= $signed({4'b0, cfg_i.clip_min_x}))
          && (px_s <  $signed({4'b0, cfg_i.clip_max_x}))
          && (px_s <  $signed({4'b0, sw_sat}));
    in_y   = !py_s[16]
          && (py_s >= $signed({4'b0, cfg_i.clip_min_y}))
          && (py_s <  $signed({4'b0, cfg_i.clip_max_y}))
          && (py_s <  $signed({4'b0, sh_sat}));
    fa       = (cfg_i.text_color[31:24] == 8'd0) ? 8'hFF : cfg_i.text_color[31:24];
    addr_mul = {{DIM_W{1'b0}}, pix_i.pixel_y[COORD_W-1:0]} * {{COORD_W{1'b0}}, sw_sat};
  end

  always_comb begin
    s2_d.we   = s1_keep_q;
    s2_d.addr = s1_addr_q + ADDR_W'(s1_px_q);
    s2_d.at   = GAMMA_ROM[div255(s1_prod_q + 16'd127)];
    s2_d.bgp  = s1_bgp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= pix_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_keep_q <= (pix_i.coverage != 8'd0) && in_x && in_y;
      s1_prod_q <= 16'(pix_i.coverage) * 16'(fa);
      s1_addr_q <= ADDR_W'(addr_mul);
      s1_px_q   <= pix_i.pixel_x[COORD_W-1:0];
      s1_bgp_q  <= pix_i.background_pixel;
      s2_q      <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule

// ===== hdl/gcab_queue.sv =====
// Short register FIFO between the front and the back of the glyph blender.
// Depends on gcab_pkg.
`timescale 1ns / 1ps

module gcab_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  gcab_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output gcab_pkg::entry_t pop_data_o
);
  import gcab_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/gcab_back.sv =====
// Back end of the glyph blender: over-operator weights, output alpha and a
// pipelined restoring divider per colour channel. Depends on gcab_pkg and gcab_pix_out_if.
`timescale 1ns / 1ps

module gcab_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [23:0]      fg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gcab_pkg::entry_t in_data_i,
  gcab_pix_out_if.source   res_o
);
  import gcab_pkg::*;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         alpha;
    logic [15:0]        den;
    logic [2:0][23:0]   rem;
    logic [2:0][7:0]    quo;
  } div_t;

  function automatic div_t div_step(input div_t s, input int unsigned sft);
    div_t        r;
    logic [24:0] trial;
    r = s;
    for (int l = 0; l < 3; l++) begin
      trial = {1'b0, s.rem[l]} - {1'b0, (24'(s.den) << sft)};
      if (!trial[24]) begin
        r.rem[l]      = trial[23:0];
        r.quo[l][sft] = 1'b1;
      end
    end
    return r;
  endfunction

  logic              en;
  logic              b1_valid_q, b1_we_q;
  logic [ADDR_W-1:0] b1_addr_q;
  logic [15:0]       b1_wa_q, b1_wb_q;
  logic [23:0]       b1_bg_q;

  logic              st_valid_q [NSTEP+1];
  div_t              st_q [NSTEP+1];
  div_t              st0_d;

  logic              out_valid_q, out_we_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [31:0]       out_pix_q;

  assign en         = !out_valid_q || res_o.ready;
  assign in_ready_o = en;

  always_comb begin
    st0_d.den   = b1_wa_q + b1_wb_q;
    st0_d.we    = b1_we_q && (st0_d.den != 16'd0);
    st0_d.addr  = b1_addr_q;
    st0_d.alpha = div255(st0_d.den);
    st0_d.quo   = '0;
    for (int l = 0; l < 3; l++) begin
      st0_d.rem[l] = 24'(b1_wa_q) * 24'(fg_i[8*l +: 8])
                   + 24'(b1_wb_q) * 24'(b1_bg_q[8*l +: 8]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= NSTEP; k++) begin
        st_valid_q[k] <= 1'b0;
      end
    end else if (en) begin
      b1_valid_q    <= in_valid_i;
      st_valid_q[0] <= b1_valid_q;
      for (int k = 0; k < NSTEP; k++) begin
        st_valid_q[k+1] <= st_valid_q[k];
      end
      out_valid_q <= st_valid_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_we_q   <= in_data_i.we;
      b1_addr_q <= in_data_i.addr;
      b1_wa_q   <= {in_data_i.at, 8'd0} - {8'd0, in_data_i.at};
      b1_wb_q   <= 16'(8'hFF - in_data_i.at) * 16'(in_data_i.bgp[31:24]);
      b1_bg_q   <= in_data_i.bgp[23:0];
      st_q[0]   <= st0_d;
      for (int k = 0; k < NSTEP; k++) begin
        st_q[k+1] <= div_step(st_q[k], NSTEP - 1 - k);
      end
      out_we_q   <= st_q[NSTEP].we;
      out_addr_q <= st_q[NSTEP].we ? st_q[NSTEP].addr : '0;
      out_pix_q  <= st_q[NSTEP].we
                  ? {st_q[NSTEP].alpha, st_q[NSTEP].quo[2], st_q[NSTEP].quo[1],
                     st_q[NSTEP].quo[0]}
                  : '0;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.write_enable  = out_we_q;
  assign res_o.pixel_address = out_addr_q;
  assign res_o.blended_pixel = out_pix_q;

endmodule

// ===== hdl/glyph_coverage_alpha_blend.sv =====
// Top level of the glyph coverage alpha blender: configuration registers,
// front end, queue and back end. Depends on gcab_pkg, the interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// Each beat on pix_i carries a pixel position, a glyph coverage byte and the
// background ARGB pixel. Each accepted beat gives exactly one beat on res_o,
// in order: write_enable, the frame address and the blended ARGB pixel. A
// coverage of zero, a clipped pixel or a zero output alpha gives
// write_enable low with address and pixel zero.
// cfg_i writes the seven registers by index (0 text color, 1 screen width,
// 2 screen height, 3..6 clip window); it is always ready. The user must
// write it only while no pixel is in flight; the block does not enforce it.
// Indexes beyond the list are ignored. Throughput is one pixel per clock
// while res_o is ready. Each pixel passes two front stages, the queue, two
// weight stages, eight divider steps of the per-channel restoring divider and
// the output register. When res_o stalls, the back end holds; the four-entry
// queue and the front keep accepting until the queue fills.
// Reset loads the register reset values and empties every stage and the queue.
module glyph_coverage_alpha_blend (
  input  logic           clk_i,
  input  logic           rst_ni,
  gcab_pix_in_if.sink    pix_i,
  gcab_pix_out_if.source res_o,
  gcab_cfg_if.sink       cfg_i
);
  import gcab_pkg::*;

  cfg_t   cfg_q;
  logic   front_valid, front_ready;
  entry_t front_data;
  logic   back_valid, back_ready;
  entry_t back_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_color    <= 32'hFFFF_FFFF;
      cfg_q.screen_width  <= DIM_W'(640);
      cfg_q.screen_height <= DIM_W'(480);
      cfg_q.clip_min_x    <= '0;
      cfg_q.clip_min_y    <= '0;
      cfg_q.clip_max_x    <= DIM_W'(MAX_DIM);
      cfg_q.clip_max_y    <= DIM_W'(MAX_DIM);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_TEXT_COLOR:    cfg_q.text_color    <= cfg_i.data;
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_i.data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_i.data[DIM_W-1:0];
        REG_CLIP_MIN_X:    cfg_q.clip_min_x    <= cfg_i.data[DIM_W-1:0];
        REG_CLIP_MIN_Y:    cfg_q.clip_min_y    <= cfg_i.data[DIM_W-1:0];
        REG_CLIP_MAX_X:    cfg_q.clip_max_x    <= cfg_i.data[DIM_W-1:0];
        REG_CLIP_MAX_Y:    cfg_q.clip_max_y    <= cfg_i.data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gcab_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_i       (pix_i),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_data_o  (front_data)
  );

  gcab_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_data),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_data)
  );

  gcab_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fg_i       (cfg_q.text_color[23:0]),
    .in_valid_i (back_valid),
    .in_ready_o (back_ready),
    .in_data_i  (back_data),
    .res_o      (res_o)
  );

  `ASSERT_IMPLIES(a_nowrite_zero, clk_i, rst_ni, res_o.valid && !res_o.write_enable, res_o.pixel_address == 24'd0 && res_o.blended_pixel == 32'd0, "skipped pixel carries nonzero data")
  `ASSERT_IMPLIES(a_write_alpha, clk_i, rst_ni, res_o.valid && res_o.write_enable, res_o.blended_pixel[31:24] != 8'd0, "written pixel has zero alpha")
  `ASSERT_NEXT(a_front_hold, clk_i, rst_ni, front_valid && !front_ready, front_valid && $stable(front_data), "front dropped a beat while the queue was full")

endmodule
